// ----- design/max_drawdown_tracker_assert.svh -----
// assertion helpers for the drawdown tracker
`ifndef MAX_DRAWDOWN_TRACKER_ASSERT_SVH
`define MAX_DRAWDOWN_TRACKER_ASSERT_SVH

// same-cycle implication, checked on every rising clock outside reset
`define MDD_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define MDD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- design/mdd_pkg.sv -----
package mdd_pkg;

   // fixed field widths
   localparam int VAL_FIELD_W = 32;
   localparam int QUO_W       = 32;
   localparam int FRAC_W      = 16;

   typedef struct packed {
      logic [VAL_FIELD_W-1:0] value;
      logic                   first;
   } req_type;

   typedef struct packed {
      logic [QUO_W-1:0] drawdown_now;
      logic [QUO_W-1:0] max_drawdown;
   } rsp_type;

   // divider status toward the sequencer
   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

// ----- design/mdd_div.sv -----
module mdd_div #(
   parameter int VALUE_WIDTH = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [VALUE_WIDTH-1:0]        rem_init,
   input  logic [mdd_pkg::QUO_W-1:0]     low_bits,
   input  logic [VALUE_WIDTH-1:0]        divisor,
   output mdd_pkg::div_stat_type         stat,
   output logic [mdd_pkg::QUO_W-1:0]     quotient
);
   import mdd_pkg::*;

   localparam int CNT_W = $clog2(QUO_W);

   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic [VALUE_WIDTH-1:0] rem_ff, rem_in;
   logic [VALUE_WIDTH-1:0] div_ff, div_in;
   logic [QUO_W-1:0]       low_ff, low_in;
   logic [QUO_W-1:0]       quo_ff, quo_in;
   logic [VALUE_WIDTH:0]   trial;

   // one restoring step: shift in next dividend bit, try subtract
   assign trial = {rem_ff, low_ff[QUO_W-1]} - {1'b0, div_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      low_in  = low_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = rem_init;
         div_in  = divisor;
         low_in  = low_bits;
         quo_in  = '0;
      end else if (busy_ff) begin
         low_in = {low_ff[QUO_W-2:0], 1'b0};
         quo_in = {quo_ff[QUO_W-2:0], ~trial[VALUE_WIDTH]};
         if (!trial[VALUE_WIDTH]) begin
            rem_in = trial[VALUE_WIDTH-1:0];
         end else begin
            rem_in = {rem_ff[VALUE_WIDTH-2:0], low_ff[QUO_W-1]};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(QUO_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      div_ff <= div_in;
      low_ff <= low_in;
      quo_ff <= quo_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quotient  = quo_ff;

endmodule

// ----- design/max_drawdown_tracker.sv -----
// running maximum drawdown of a stream of signed portfolio values. each req beat carries a
// value and a first flag; first restarts the series (peak = value, maximum cleared). the peak
// rises to any larger value, and while it is positive the drawdown is
// (peak - value) * 100 / peak in percent, unsigned q16.16, truncated, saturating at all ones.
// each req beat yields one rsp beat with the current and the worst drawdown of the series;
// with a peak that is not positive the current drawdown is zero. one item is in work at a
// time; it goes from accept to result through the setup steps (peak update, scale by 100,
// overflow check), a restoring divider that produces one quotient bit per cycle, a register
// that carries the divider's done flag to the sequencer, and the load of the output
// register, which waits while an earlier result is held by rsp_stall. req_stall drops again
// in the cycle after the output load. the output register lets the next req beat be taken
// while an earlier result still waits on rsp_stall.
module max_drawdown_tracker #(
   parameter int VALUE_WIDTH = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  mdd_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output mdd_pkg::rsp_type rsp_data
);
   import mdd_pkg::*;

   // scaled difference is below 2^(VALUE_WIDTH+7); keep at least one bit above the fraction
   localparam int SC_W = (VALUE_WIDTH + 7 > FRAC_W + 1) ? VALUE_WIDTH + 7 : FRAC_W + 1;

   // sequencer states
   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_PEAK  = 3'd1;
   localparam logic [2:0] ST_SCALE = 3'd2;
   localparam logic [2:0] ST_START = 3'd3;
   localparam logic [2:0] ST_DIV   = 3'd4;
   localparam logic [2:0] ST_FIN   = 3'd5;

   logic [2:0]                    state_ff, state_in;
   logic signed [VALUE_WIDTH-1:0] val_ff, val_in;
   logic                          first_ff, first_in;
   logic signed [VALUE_WIDTH-1:0] peak_ff, peak_in;
   logic [QUO_W-1:0]              worst_ff, worst_in;
   logic [VALUE_WIDTH:0]          diff_ff, diff_in;
   logic [SC_W-1:0]               scaled_ff, scaled_in;
   logic                          pos_ff, pos_in;
   logic                          sat_ff, sat_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   rsp_type                       rsp_ff, rsp_in;

   logic signed [VALUE_WIDTH-1:0] req_val;
   logic signed [VALUE_WIDTH-1:0] peak_base;
   logic signed [VALUE_WIDTH-1:0] peak_new;
   logic [SC_W-1:0]               diff_ext;
   logic [VALUE_WIDTH-1:0]        high_part;
   logic [QUO_W-1:0]              now_val;
   logic [QUO_W-1:0]              worst_new;
   logic                          out_free;
   logic                          req_take;
   logic                          div_start;
   div_stat_type                  div_stat;
   logic [QUO_W-1:0]              div_quo;

   // low VALUE_WIDTH bits of the field, or the field sign extended when wider
   generate
      if (VALUE_WIDTH <= VAL_FIELD_W) begin : g_val_narrow
         assign req_val = req_data.value[VALUE_WIDTH-1:0];
      end else begin : g_val_wide
         assign req_val = {{(VALUE_WIDTH - VAL_FIELD_W){req_data.value[VAL_FIELD_W-1]}},
                           req_data.value};
      end
   endgenerate

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // new series starts from the item's own value
   assign peak_base = first_ff ? val_ff : peak_ff;
   assign peak_new  = (val_ff > peak_base) ? val_ff : peak_base;

   // times 100 as 64 + 32 + 4
   assign diff_ext = SC_W'(diff_ff);

   // upper dividend bits, the divider's starting remainder; must stay below the peak
   assign high_part = VALUE_WIDTH'(scaled_ff[SC_W-1:FRAC_W]);
   assign div_start = (state_ff == ST_START);

   assign now_val   = !pos_ff ? '0 : (sat_ff ? '1 : div_quo);
   assign worst_new = (now_val > worst_ff) ? now_val : worst_ff;

   always_comb begin
      state_in     = state_ff;
      val_in       = val_ff;
      first_in     = first_ff;
      peak_in      = peak_ff;
      worst_in     = worst_ff;
      diff_in      = diff_ff;
      scaled_in    = scaled_ff;
      pos_in       = pos_ff;
      sat_in       = sat_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               val_in   = req_val;
               first_in = req_data.first;
               state_in = ST_PEAK;
            end
         end
         ST_PEAK: begin
            // peak update, maximum cleared on a new series
            peak_in  = peak_new;
            pos_in   = (peak_new > 0);
            diff_in  = {peak_new[VALUE_WIDTH-1], peak_new} - {val_ff[VALUE_WIDTH-1], val_ff};
            if (first_ff) begin
               worst_in = '0;
            end
            state_in = ST_SCALE;
         end
         ST_SCALE: begin
            scaled_in = (diff_ext << 6) + (diff_ext << 5) + (diff_ext << 2);
            state_in  = ST_START;
         end
         ST_START: begin
            // 65536 percent or more does not fit q16.16
            sat_in   = (high_part >= $unsigned(peak_ff));
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (div_stat.done) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (out_free) begin
               rsp_valid_in        = 1'b1;
               rsp_in.drawdown_now = now_val;
               rsp_in.max_drawdown = worst_new;
               worst_in            = worst_new;
               state_in            = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         peak_ff      <= '0;
         worst_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         peak_ff      <= peak_in;
         worst_ff     <= worst_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      val_ff    <= val_in;
      first_ff  <= first_in;
      diff_ff   <= diff_in;
      scaled_ff <= scaled_in;
      pos_ff    <= pos_in;
      sat_ff    <= sat_in;
      rsp_ff    <= rsp_in;
   end

   // bit-serial divide: floor(scaled * 2^16 / peak), one quotient bit per cycle
   mdd_div #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .rem_init (high_part),
      .low_bits ({scaled_ff[FRAC_W-1:0], {(QUO_W - FRAC_W){1'b0}}}),
      .divisor  ($unsigned(peak_ff)),
      .stat     (div_stat),
      .quotient (div_quo)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`include "max_drawdown_tracker_assert.svh"

   // the reported maximum never trails the current drawdown of the same beat
   `MDD_ASSERT_IMPL(a_max_covers_now, rsp_valid_in && !(rsp_valid_ff && rsp_stall),
      rsp_in.max_drawdown >= rsp_in.drawdown_now, "max drawdown below current drawdown")
   // divider runs only between start and its done flag
   `MDD_ASSERT_IMPL(a_div_idle_outside, div_stat.busy || div_stat.done,
      state_ff == ST_DIV, "divider active outside the divide phase")
   // starting the divider always makes it busy next cycle
   `MDD_ASSERT_NEXT(a_div_starts, div_start, div_stat.busy && state_ff == ST_DIV,
      "divider did not start")

endmodule
